FILE: src/tpe_pkg.sv
// ----------------------------------------------------------------------------
// tpe_pkg
// Types, constants and arithmetic helpers for the pose inversion / Euler block.
// ----------------------------------------------------------------------------
`default_nettype none

package tpe_pkg;

   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [17:0] PI_Q13      = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
   localparam logic [29:0]        INV_GAIN    = 30'd652032874;

   localparam logic signed [33:0] ATAN_TAB [32] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
      34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
      34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
      34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
      34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
      34'sd1024,      34'sd512,       34'sd256,       34'sd128,
      34'sd64,        34'sd32,        34'sd16,        34'sd8,
      34'sd4,         34'sd2,         34'sd1,         34'sd0
   };

   typedef struct packed {
      logic signed [35:0] x;
      logic signed [35:0] y;
      logic signed [33:0] z;
      logic               zero;
   } cordic_type;

   typedef struct packed {
      logic [8:0][15:0]  rot;
      logic [2:0][31:0]  tpos;
      logic [8:0][47:0]  prod;
      logic [2:0][31:0]  cam;
      cordic_type        yaw;
      cordic_type        roll;
      cordic_type        hyp;
      cordic_type        pitch;
      logic [46:0]       mlo;
      logic [46:0]       mhi;
      logic [15:0]       yaw_a;
      logic [15:0]       roll_a;
      logic [15:0]       pitch_a;
   } stage_type;

   function automatic logic signed [35:0] scale16(logic [15:0] v);
      scale16 = {{4{v[15]}}, v, 16'd0};
   endfunction

   function automatic logic [47:0] smul(logic [15:0] a, logic [31:0] b);
      logic signed [47:0] ae;
      logic signed [47:0] be;
      ae = {{32{a[15]}}, a};
      be = {{16{b[31]}}, b};
      smul = ae * be;
   endfunction

   function automatic cordic_type cordic_pre(logic signed [35:0] x, logic signed [35:0] y);
      cordic_type c;
      c.zero = (x == 36'sd0) && (y == 36'sd0);
      c.x = x;
      c.y = y;
      c.z = '0;
      if (x < 0) begin
         if (y >= 0) begin
            c.x = y;
            c.y = -x;
            c.z = HALF_PI_Q30;
         end else begin
            c.x = -y;
            c.y = x;
            c.z = -HALF_PI_Q30;
         end
      end
      cordic_pre = c;
   endfunction

   function automatic cordic_type cordic_iter(cordic_type c, logic [4:0] i);
      cordic_type         o;
      logic signed [35:0] x;
      logic signed [35:0] y;
      logic signed [35:0] xs;
      logic signed [35:0] ys;
      x  = c.x;
      y  = c.y;
      xs = x >>> i;
      ys = y >>> i;
      o = c;
      if (y >= 0) begin
         o.x = x + ys;
         o.y = y - xs;
         o.z = c.z + ATAN_TAB[i];
      end else begin
         o.x = x - ys;
         o.y = y + xs;
         o.z = c.z - ATAN_TAB[i];
      end
      cordic_iter = o;
   endfunction

   function automatic logic [15:0] angle_out(cordic_type c);
      logic signed [34:0] t;
      logic signed [17:0] r;
      t = {c.z[33], c.z} + 35'sd65536;
      r = t[34:17];
      if (r >= PI_Q13) begin
         r = r - TWO_PI_Q13;
      end else if (r < -PI_Q13) begin
         r = r + TWO_PI_Q13;
      end
      angle_out = c.zero ? 16'd0 : r[15:0];
   endfunction

   function automatic logic [31:0] pos_out(logic [47:0] a, logic [47:0] b, logic [47:0] c);
      logic signed [50:0] acc;
      logic signed [50:0] rnd;
      logic signed [36:0] r;
      acc = -({{3{a[47]}}, a} + {{3{b[47]}}, b} + {{3{c[47]}}, c});
      rnd = acc + 51'sd8192;
      r   = rnd[50:14];
      if (r > 37'sd2147483647) begin
         pos_out = 32'h7FFF_FFFF;
      end else if (r < -37'sd2147483648) begin
         pos_out = 32'h8000_0000;
      end else begin
         pos_out = r[31:0];
      end
   endfunction

endpackage

`default_nettype wire

FILE: src/tag_pose_inversion_to_euler_top.sv
// ----------------------------------------------------------------------------
// tag_pose_inversion_to_euler_top
// Inverts a tag pose and returns camera position plus ZYX yaw/pitch/roll.
//
// channel  dir  word
// req_     in   rotation (9 x Q2.14) and translation (3 x Q16.16)
// rsp_     out  camera position (3 x Q16.16) and yaw/pitch/roll (3 x Q3.13)
//
// One word per cycle sustained while rsp_tready stays high.
// Depth is set by two chained CORDIC passes (hypotenuse, then pitch atan2)
// plus input capture, pre-rotation, gain multiply and output stages.
// Each stage holds while the next one is full and stalled; bubbles collapse.
// Synchronous reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module tag_pose_inversion_to_euler_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
   // tag_pos_x, tag_pos_y, tag_pos_z
   input  wire logic [239:0] req_tdata,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // cam_x, cam_y, cam_z, yaw_angle, pitch_angle, roll_angle
   output      logic [143:0] rsp_tdata
);

   localparam int CS    = CORDIC_STEPS;
   localparam int DEPTH = 2 * CS + 5;
   localparam int S_PRE = 1;
   localparam int S_MUL = CS + 2;
   localparam int S_HYP = CS + 3;
   localparam int S_OUT = 2 * CS + 4;

   tpe_pkg::stage_type  pipe_ff [DEPTH];
   tpe_pkg::stage_type  pipe_in [DEPTH];
   logic [DEPTH-1:0]    valid_ff;
   logic [DEPTH:0]      adv;

   assign adv[DEPTH] = rsp_tready;

   genvar k;
   generate
      for (k = 0; k < DEPTH; k++) begin : g_stage
         assign adv[k] = !valid_ff[k] || adv[k+1];

         if (k == 0) begin : g_cap
            always_comb begin
               pipe_in[k] = '0;
               for (int i = 0; i < 9; i++) begin
                  pipe_in[k].rot[i] = req_tdata[16*i +: 16];
               end
               for (int j = 0; j < 3; j++) begin
                  pipe_in[k].tpos[j] = req_tdata[144 + 32*j +: 32];
               end
            end
         end else begin : g_work
            always_comb begin
               tpe_pkg::stage_type s;
               s = pipe_ff[k-1];
               if (k == S_PRE) begin
                  for (int i = 0; i < 3; i++) begin
                     for (int j = 0; j < 3; j++) begin
                        s.prod[3*i+j] = tpe_pkg::smul(s.rot[i+3*j], s.tpos[j]);
                     end
                  end
                  s.yaw  = tpe_pkg::cordic_pre(tpe_pkg::scale16(s.rot[0]),
                                               tpe_pkg::scale16(s.rot[1]));
                  s.roll = tpe_pkg::cordic_pre(tpe_pkg::scale16(s.rot[8]),
                                               tpe_pkg::scale16(s.rot[5]));
                  s.hyp  = tpe_pkg::cordic_pre(
                              s.rot[8][15] ? -tpe_pkg::scale16(s.rot[8])
                                           : tpe_pkg::scale16(s.rot[8]),
                              tpe_pkg::scale16(s.rot[5]));
               end else if (k < S_MUL) begin
                  if (k == S_PRE + 1) begin
                     for (int i = 0; i < 3; i++) begin
                        s.cam[i] = tpe_pkg::pos_out(s.prod[3*i], s.prod[3*i+1],
                                                    s.prod[3*i+2]);
                     end
                  end
                  s.yaw  = tpe_pkg::cordic_iter(s.yaw,  5'(k - 2));
                  s.roll = tpe_pkg::cordic_iter(s.roll, 5'(k - 2));
                  s.hyp  = tpe_pkg::cordic_iter(s.hyp,  5'(k - 2));
               end else if (k == S_MUL) begin
                  s.yaw_a  = tpe_pkg::angle_out(s.yaw);
                  s.roll_a = tpe_pkg::angle_out(s.roll);
                  s.mlo    = 47'(s.hyp.x[16:0]) * 47'(tpe_pkg::INV_GAIN);
                  s.mhi    = 47'(s.hyp.x[33:17]) * 47'(tpe_pkg::INV_GAIN);
               end else if (k == S_HYP) begin
                  logic [63:0] full;
                  full = {s.mhi, 17'd0} + 64'(s.mlo);
                  s.pitch = tpe_pkg::cordic_pre({2'b00, full[63:30]},
                                                -tpe_pkg::scale16(s.rot[2]));
               end else if (k < S_OUT) begin
                  s.pitch = tpe_pkg::cordic_iter(s.pitch, 5'(k - S_HYP - 1));
               end else begin
                  s.pitch_a = tpe_pkg::angle_out(s.pitch);
               end
               pipe_in[k] = s;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (adv[k]) begin
               valid_ff[k] <= (k == 0) ? req_tvalid : valid_ff[(k == 0) ? 0 : k-1];
            end
         end

         always_ff @(posedge clock) begin
            if (adv[k]) begin
               pipe_ff[k] <= pipe_in[k];
            end
         end
      end
   endgenerate

   assign req_tready = adv[0];
   assign rsp_tvalid = valid_ff[DEPTH-1];
   assign rsp_tdata  = {pipe_ff[DEPTH-1].roll_a, pipe_ff[DEPTH-1].pitch_a,
                        pipe_ff[DEPTH-1].yaw_a,  pipe_ff[DEPTH-1].cam[2],
                        pipe_ff[DEPTH-1].cam[1], pipe_ff[DEPTH-1].cam[0]};

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted word missing from first stage");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[DEPTH-1] |-> req_tready)
      else $error("input stalled with empty output stage");

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[111:96]) >= -16'sd25736) &&
                     ($signed(rsp_tdata[111:96]) < 16'sd25736))
      else $error("yaw out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[127:112]) >= -16'sd25736) &&
                     ($signed(rsp_tdata[127:112]) < 16'sd25736))
      else $error("pitch out of range");

endmodule

`default_nettype wire
